// File: hw/rtl/ted_pkg.sv
// ============================================================================
// ted_pkg - shared definitions for the trie edit distance block
// Field widths, register indexes, edit costs and the control/status structs
// passed between the sequencer and the datapath.
// ============================================================================
package ted_pkg;

    localparam int CHAR_W      = 8;
    localparam int DEPTH_W     = 7;
    localparam int DIST_W      = 7;
    localparam int CELL_W      = 8;
    localparam int LEN_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam int MAX_QUERY_DEF    = 16;
    localparam int MAX_DEPTH_DEF    = 128;
    localparam int QUERY_CHARS_HELD = 16;

    localparam int COST_EDIT = 1;
    localparam int COST_INS  = 1;
    localparam int COST_DEL  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_HI  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LEN = 2'd2;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic start;   // Capture the accepted item and read element 0.
        logic step;    // Compute one row element.
        logic finish;  // Load the result register.
    } t_ctrl_cmd;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic depth_zero;  // The offered item names the root.
        logic last;        // The element being computed is the last one.
    } t_dp_status;

endpackage

// File: hw/rtl/ted_if.sv
// ============================================================================
// ted_if - channel interfaces of the trie edit distance block
// Node input channel, result output channel and configuration write channel.
// ============================================================================
interface ted_node_if;
    import ted_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  node_char;
    logic [DEPTH_W-1:0] node_depth;

    modport source (output valid, node_char, node_depth, input ready);
    modport sink   (input valid, node_char, node_depth, output ready);
endinterface

interface ted_result_if;
    import ted_pkg::*;

    logic               valid;
    logic               ready;
    logic [DIST_W-1:0]  word_distance;
    logic [DEPTH_W-1:0] echo_depth;

    modport source (output valid, word_distance, echo_depth, input ready);
    modport sink   (input valid, word_distance, echo_depth, output ready);
endinterface

interface ted_cfg_if;
    import ted_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/ted_ctrl.sv
// ============================================================================
// ted_ctrl - sequencer of the trie edit distance block
// Accepts a node item, steps the datapath once per query character and hands
// the result to the output register when it is free.
// ============================================================================
module ted_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  ted_pkg::t_dp_status i_sts,
    output ted_pkg::t_ctrl_cmd  o_cmd
);
    import ted_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, n_in_ready;
    logic   r_out_valid, n_out_valid;
    logic   in_fire;
    logic   out_free;

    assign in_fire  = i_in_valid && r_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd.start  = in_fire;
        o_cmd.step   = (r_state == S_RUN);
        o_cmd.finish = (r_state == S_DONE) && out_free;
    end

    always_comb begin
        n_state     = r_state;
        n_in_ready  = r_in_ready;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_in_ready = 1'b0;
                    n_state    = i_sts.depth_zero ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                if (i_sts.last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_in_ready  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state    = S_IDLE;
                n_in_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= n_in_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    // Input is taken only while the sequencer is idle.
    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ready |-> (r_state == S_IDLE))
        else $error("ted_ctrl: input ready outside idle");

    // The result register is never overwritten while it holds an untaken result.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("ted_ctrl: result register overwritten");

    // A non-root item starts the row walk in the next cycle.
    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !i_sts.depth_zero) |=> (r_state == S_RUN))
        else $error("ted_ctrl: row walk did not start");

    // The last element ends the walk.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RUN) && i_sts.last) |=> (r_state == S_DONE))
        else $error("ted_ctrl: row walk did not end after last element");

endmodule

// File: hw/rtl/ted_dp.sv
// ============================================================================
// ted_dp - datapath of the trie edit distance block
// Query registers, row store and the one-element-per-cycle edit cell.
// ============================================================================
module ted_dp #(
    parameter int MAX_QUERY = ted_pkg::MAX_QUERY_DEF,
    parameter int MAX_DEPTH = ted_pkg::MAX_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ted_pkg::t_ctrl_cmd              i_cmd,
    output ted_pkg::t_dp_status             o_sts,
    input  logic [ted_pkg::CHAR_W-1:0]      i_node_char,
    input  logic [ted_pkg::DEPTH_W-1:0]     i_node_depth,
    input  logic                            i_cfg_we,
    input  logic [ted_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ted_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic [ted_pkg::DIST_W-1:0]      o_word_distance,
    output logic [ted_pkg::DEPTH_W-1:0]     o_echo_depth
);
    import ted_pkg::*;

    localparam int IdxW    = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
    localparam int RowW    = $clog2(MAX_DEPTH);
    localparam int WideW   = (RowW > DEPTH_W) ? RowW : DEPTH_W;
    localparam int AddrW   = RowW + IdxW;
    localparam int MemDepth = MAX_DEPTH << IdxW;
    localparam int LenCap  = (QUERY_CHARS_HELD < MAX_QUERY) ? QUERY_CHARS_HELD : MAX_QUERY;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_q_lo;
    logic [CFG_DATA_W-1:0] r_q_hi;
    logic [LEN_W-1:0]      r_q_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_lo  <= '0;
            r_q_hi  <= '0;
            r_q_len <= LEN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_QUERY_LO:  r_q_lo  <= i_cfg_data;
                CFG_QUERY_HI:  r_q_hi  <= i_cfg_data;
                CFG_QUERY_LEN: r_q_len <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Item registers.
    logic [CHAR_W-1:0]  r_ch;
    logic [DEPTH_W-1:0] r_depth;
    logic [RowW-1:0]    r_row;
    logic [RowW-1:0]    r_prow;
    logic               r_wr_ok;
    logic               r_par_root;
    logic               r_par_oob;
    logic               r_root;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   r_idx;
    logic [CELL_W-1:0]  r_up;
    logic [CELL_W-1:0]  r_diag;
    logic [CELL_W-1:0]  r_rd_data;
    logic [DIST_W-1:0]  r_word_distance;
    logic [DEPTH_W-1:0] r_echo_depth;

    logic [CELL_W-1:0]  mem [0:MemDepth-1];

    logic [DEPTH_W-1:0] in_parent;
    logic [WideW-1:0]   in_depth_w;
    logic [WideW-1:0]   in_parent_w;
    logic [LEN_W-1:0]   eff_len;
    logic [AddrW-1:0]   rd_addr;
    logic [AddrW-1:0]   wr_addr;
    logic [CELL_W-1:0]  left;
    logic [CELL_W-1:0]  q_char;
    logic [CELL_W:0]    c_diag;
    logic [CELL_W:0]    c_up;
    logic [CELL_W:0]    c_left;
    logic [CELL_W:0]    c_min;
    logic [CELL_W-1:0]  cur;
    logic [2*CFG_DATA_W-1:0] q_all;

    assign in_parent   = i_node_depth - DEPTH_W'(1);
    assign in_depth_w  = WideW'(i_node_depth);
    assign in_parent_w = WideW'(in_parent);

    always_comb begin
        eff_len = r_q_len;
        if (eff_len == '0) begin
            eff_len = LEN_W'(1);
        end
        if (eff_len > LEN_W'(LenCap)) begin
            eff_len = LEN_W'(LenCap);
        end
    end

    assign o_sts.depth_zero = (i_node_depth == '0);
    assign o_sts.last       = (r_idx == r_len - LEN_W'(1));

    // Element 0 of the parent row is read as the item is accepted, element i+1
    // while element i is being computed.
    always_comb begin
        if (i_cmd.start) begin
            rd_addr = {in_parent_w[RowW-1:0], IdxW'(0)};
        end else begin
            rd_addr = {r_prow, IdxW'(r_idx + LEN_W'(1))};
        end
    end
    assign wr_addr = {r_row, IdxW'(r_idx)};

    assign q_all  = {r_q_hi, r_q_lo};
    assign q_char = q_all[{r_idx[3:0], 3'b000} +: CELL_W];

    always_comb begin
        if (r_par_root) begin
            left = CELL_W'(r_idx) + CELL_W'(1);
        end else if (r_par_oob) begin
            left = '0;
        end else begin
            left = r_rd_data;
        end
        c_diag = {1'b0, r_diag} + (CELL_W+1)'(COST_EDIT);
        c_up   = {1'b0, r_up}   + (CELL_W+1)'(COST_DEL);
        c_left = {1'b0, left}   + (CELL_W+1)'(COST_INS);
        c_min  = (c_up < c_left) ? c_up : c_left;
        c_min  = (c_diag < c_min) ? c_diag : c_min;
        if (q_char == r_ch) begin
            cur = r_diag;
        end else if (c_min[CELL_W]) begin
            cur = '1;
        end else begin
            cur = c_min[CELL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && r_wr_ok) begin
            mem[wr_addr] <= cur;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ch       <= i_node_char;
            r_depth    <= i_node_depth;
            r_row      <= in_depth_w[RowW-1:0];
            r_prow     <= in_parent_w[RowW-1:0];
            r_wr_ok    <= (32'(i_node_depth) < MAX_DEPTH);
            r_par_root <= (in_parent == '0);
            r_par_oob  <= (32'(in_parent) >= MAX_DEPTH);
            r_root     <= (i_node_depth == '0);
            r_len      <= eff_len;
            r_idx      <= '0;
            r_up       <= CELL_W'(i_node_depth);
            r_diag     <= CELL_W'(in_parent);
        end else if (i_cmd.step) begin
            r_up   <= cur;
            r_diag <= left;
            r_idx  <= r_idx + LEN_W'(1);
        end
        if (i_cmd.finish) begin
            if (r_root) begin
                r_word_distance <= DIST_W'(r_len);
                r_echo_depth    <= '0;
            end else begin
                r_word_distance <= (r_up[CELL_W-1]) ? '1 : r_up[DIST_W-1:0];
                r_echo_depth    <= r_depth;
            end
        end
    end

    assign o_word_distance = r_word_distance;
    assign o_echo_depth    = r_echo_depth;

endmodule

// File: hw/rtl/trie_edit_distance_rows.sv
// ============================================================================
// trie_edit_distance_rows - Levenshtein rows over a depth-first trie walk
// Computes one edit-distance row per trie node against a configured query.
// ============================================================================
// Usage: write the query characters and length on the configuration channel
// while the block is idle (index 0 and 1 hold the characters, index 2 the
// length). Then offer trie nodes in depth-first order on the node channel;
// each item carries the edge character and the node depth. For every item
// one result item comes out carrying the distance between the node prefix
// and the whole query word, plus the node depth.
// Sequence: an item is accepted in the idle state, then the row walk computes
// one element per query character, reading each parent row element from the
// row store ahead of its use, and the done state loads the result register
// once it is free. A root item (depth zero) goes from the idle state straight
// to the done state. The row store has one read and one write port.
// Reset clears the sequencer, the output valid and the query characters and
// sets the query length to one; the row store is not cleared, and a parent
// row must be written before use.
// If the receiver stalls, the finished result waits in the result register
// while the next item is accepted and computed; that item then waits for
// the register to free before the block takes another.
// ============================================================================
module trie_edit_distance_rows #(
    parameter int MAX_QUERY = ted_pkg::MAX_QUERY_DEF,
    parameter int MAX_DEPTH = ted_pkg::MAX_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ted_node_if.sink    i_node,
    ted_result_if.source o_result,
    ted_cfg_if.sink     i_cfg
);
    import ted_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status sts;
    logic       in_ready;
    logic       out_valid;

    // Configuration writes are always taken; they only load registers.
    assign i_cfg.ready = 1'b1;

    ted_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_node.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_result.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ted_dp #(
        .MAX_QUERY (MAX_QUERY),
        .MAX_DEPTH (MAX_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_node_char     (i_node.node_char),
        .i_node_depth    (i_node.node_depth),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .o_word_distance (o_result.word_distance),
        .o_echo_depth    (o_result.echo_depth)
    );

    assign i_node.ready   = in_ready;
    assign o_result.valid = out_valid;

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb - self-checking bench for trie_edit_distance_rows
// Walks trie nodes depth first against several query words and lengths. A
// row predictor inside a small scoreboard works out the distance for each
// accepted item, and every result item is checked against it in order.
// ============================================================================
module tb;
    import ted_pkg::*;

    // Generous wall for the whole run; a correct run needs well under a tenth.
    localparam int  RUN_LIMIT_NS   = 2_000_000;
    // Cycles allowed after the last result before the verdict.
    localparam int  SETTLE_CYCLES  = 40;
    localparam int  MAX_REPORTS    = 100;
    localparam byte unsigned CH_A  = 8'h61;

    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic [DEPTH_W-1:0] depth;
    } t_dist_item;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps a private copy of the query registers and the row
    // store, computes one distance per accepted node, and compares results.
    // ------------------------------------------------------------------------
    class edit_row_scoreboard;
        logic [CELL_W-1:0]        rows [MAX_DEPTH_DEF][MAX_QUERY_DEF];
        logic [MAX_QUERY_DEF-1:0] row_written [MAX_DEPTH_DEF];
        logic [CFG_DATA_W-1:0]    q_lo;
        logic [CFG_DATA_W-1:0]    q_hi;
        logic [LEN_W-1:0]         q_len;
        t_dist_item               expected_dist [$];
        int                       errors;

        function new();
            q_lo   = '0;
            q_hi   = '0;
            q_len  = LEN_W'(1);
            errors = 0;
            foreach (row_written[d]) row_written[d] = '0;
        endfunction

        task report_mismatch(input string msg);
            if (errors < MAX_REPORTS) $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        // Zero counts as one and anything past the held characters saturates.
        function int unsigned active_length();
            int unsigned n;
            n = q_len;
            if (n == 0) n = 1;
            if (n > QUERY_CHARS_HELD) n = QUERY_CHARS_HELD;
            if (n > MAX_QUERY_DEF) n = MAX_QUERY_DEF;
            return n;
        endfunction

        function logic [CHAR_W-1:0] query_char(input int unsigned i);
            return (i < 8) ? q_lo[i*8 +: 8] : q_hi[(i-8)*8 +: 8];
        endfunction

        function void note_query_write(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_QUERY_LO:  q_lo  = value;
                CFG_QUERY_HI:  q_hi  = value;
                CFG_QUERY_LEN: q_len = value[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // A node at this depth may be offered only if its parent row holds
        // every element that the current query length will read.
        function bit parent_ready(input int unsigned depth);
            int unsigned n;
            n = active_length();
            if (depth <= 1) return 1'b1;
            for (int unsigned i = 0; i < n; i++)
                if (!row_written[depth-1][i]) return 1'b0;
            return 1'b1;
        endfunction

        function int pending();
            return expected_dist.size();
        endfunction

        function void note_node(input logic [CHAR_W-1:0] ch,
                                input logic [DEPTH_W-1:0] depth);
            t_dist_item  item;
            int unsigned n;
            int unsigned parent;
            int unsigned up;
            int unsigned diag;
            int unsigned left;
            int unsigned cur;
            n = active_length();
            // The root row is never stored; its last element is the length.
            if (depth == 0) begin
                item.distance = DIST_W'(n);
                item.depth    = '0;
                expected_dist.push_back(item);
                return;
            end
            parent = depth - 1;
            up     = depth;
            diag   = parent;
            cur    = 0;
            for (int unsigned i = 0; i < n; i++) begin
                left = (parent == 0) ? i + 1 : rows[parent][i];
                if (query_char(i) == ch) begin
                    cur = diag;
                end else begin
                    cur = diag + COST_EDIT;
                    if (up + COST_DEL < cur) cur = up + COST_DEL;
                    if (left + COST_INS < cur) cur = left + COST_INS;
                end
                if (cur > 255) cur = 255;
                if (depth < MAX_DEPTH_DEF) begin
                    rows[depth][i]        = cur[CELL_W-1:0];
                    row_written[depth][i] = 1'b1;
                end
                up   = cur;
                diag = left;
            end
            item.distance = (cur > 127) ? DIST_W'(127) : cur[DIST_W-1:0];
            item.depth    = depth;
            expected_dist.push_back(item);
        endfunction

        task check_result(input logic [DIST_W-1:0] distance,
                          input logic [DEPTH_W-1:0] depth);
            t_dist_item want;
            if (expected_dist.size() == 0) begin
                report_mismatch($sformatf("result dist=%0d depth=%0d with none expected",
                                          distance, depth));
            end else begin
                want = expected_dist.pop_front();
                if (distance !== want.distance)
                    report_mismatch($sformatf("word_distance %0d, expected %0d (depth %0d)",
                                              distance, want.distance, want.depth));
                if (depth !== want.depth)
                    report_mismatch($sformatf("echo_depth %0d, expected %0d",
                                              depth, want.depth));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block itself.
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    ted_node_if   node_ch();
    ted_result_if result_ch();
    ted_cfg_if    cfg_ch();

    trie_edit_distance_rows dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_node   (node_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    edit_row_scoreboard sb;

    // When low, neither the sender nor the receiver holds back.
    bit          idle_en;
    int unsigned stall_left;
    int unsigned roll;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // Every handshake is seen at the rising edge, before the block's own
    // registers move, so the order of processes within the step is moot.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.note_query_write(cfg_ch.index, cfg_ch.data);
            if (node_ch.valid && node_ch.ready)
                sb.note_node(node_ch.node_char, node_ch.node_depth);
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.word_distance, result_ch.echo_depth);
        end
    end

    // Result receiver. Most stalls are single cycles; a few are long enough
    // that a finished result sits in its register while the next item is
    // computed behind it, which is the block's only back-pressure path.
    always @(negedge i_clk) begin
        roll = $urandom_range(999);
        if (!idle_en) begin
            stall_left = 0;
            result_ch.ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end else if (roll < 60) begin
            result_ch.ready <= 1'b0;
        end else if (roll < 62) begin
            stall_left = $urandom_range(30, 10);
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. Each task starts and ends at a falling edge. A node item that
    // follows another with no gap keeps valid high, so valid never gets two
    // assignments in one step.
    // ------------------------------------------------------------------------
    task automatic send_node(input logic [CHAR_W-1:0] ch, input logic [DEPTH_W-1:0] depth);
        int unsigned gap;
        if (idle_en && $urandom_range(99) < 9) begin
            // Short and long gaps, so they land on every step of a row.
            gap = ($urandom_range(3) == 0) ? $urandom_range(20, 4) : $urandom_range(3, 1);
            node_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        node_ch.valid      <= 1'b1;
        node_ch.node_char  <= ch;
        node_ch.node_depth <= depth;
        @(posedge i_clk);
        while (!node_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold the node channel and wait for every outstanding result. Always
    // ends at a falling edge, so a send may follow right away.
    task automatic drain_results();
        node_ch.valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    // Writes all three registers; only called with the block drained.
    task automatic write_query(input logic [CFG_DATA_W-1:0] lo,
                               input logic [CFG_DATA_W-1:0] hi,
                               input logic [CFG_DATA_W-1:0] len_word);
        logic [CFG_IDX_W-1:0]  idx  [3];
        logic [CFG_DATA_W-1:0] word [3];
        idx[0] = CFG_QUERY_LO;  word[0] = lo;
        idx[1] = CFG_QUERY_HI;  word[1] = hi;
        idx[2] = CFG_QUERY_LEN; word[2] = len_word;
        for (int k = 0; k < 3; k++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[k];
            cfg_ch.data  <= word[k];
            @(posedge i_clk);
            while (!cfg_ch.ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Query bytes either from a four-letter alphabet, so that matches are
    // common, or fully random.
    function automatic logic [CFG_DATA_W-1:0] random_query_word(input bit alpha);
        logic [CFG_DATA_W-1:0] w;
        for (int b = 0; b < 8; b++)
            w[b*8 +: 8] = alpha ? CHAR_W'(CH_A + $urandom_range(3))
                                : CHAR_W'($urandom_range(255));
        return w;
    endfunction

    // Depth-first walk with random content. Mostly it descends to a child or
    // returns to an ancestor's sibling; now and then it offers a root item or
    // jumps to any depth whose parent row is already in the store. A dive runs
    // straight from depth one to the deepest node. The walk may pause once
    // until the block has returned every result.
    task automatic run_walk(input int count, input bit dive, input bit alpha,
                            input int pause_at);
        int unsigned r;
        int unsigned cur;
        int unsigned d;
        logic [CHAR_W-1:0] ch;
        cur = 0;
        for (int k = 0; k < count; k++) begin
            if (k == pause_at) drain_results();
            r = $urandom_range(99);
            if (dive || r < 55)
                d = (cur < 127) ? cur + 1 : $urandom_range(127, 1);
            else if (r < 85)
                d = $urandom_range((cur > 1) ? cur : 1, 1);
            else if (r < 92)
                d = 0;
            else
                d = $urandom_range(127, 1);
            // Never read a parent row the store does not hold in full.
            if (d != 0 && !sb.parent_ready(d)) d = (cur < 127) ? cur + 1 : 1;
            ch = (alpha && $urandom_range(99) < 70) ? CHAR_W'(CH_A + $urandom_range(3))
                                                    : CHAR_W'($urandom_range(255));
            send_node(ch, DEPTH_W'(d));
            if (d != 0) cur = d;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin
        logic [CFG_DATA_W-1:0] len_word;
        bit                    alpha;

        sb                    = new();
        idle_en               = 1'b1;
        stall_left            = 0;
        i_rst_n               = 1'b0;
        node_ch.valid         = 1'b0;
        node_ch.node_char     = '0;
        node_ch.node_depth    = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = CFG_QUERY_LO;
        cfg_ch.data           = '0;
        result_ch.ready       = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: a one-character query of byte zero. A root item
        // answers with the query length; the first rows match or miss on the
        // lowest and highest character codes.
        send_node(8'h5A, 7'd0);
        send_node(8'h00, 7'd1);
        send_node(8'hFF, 7'd1);
        send_node(8'hFF, 7'd2);

        // Full sixteen-character query "abcdefghijklmnop": a matching path,
        // a mismatch, the highest code, a root item and a step back up.
        drain_results();
        write_query(64'h6867_6665_6463_6261, 64'h706F_6E6D_6C6B_6A69, 64'd16);
        send_node(CH_A, 7'd1);
        send_node(CH_A + 8'd1, 7'd2);
        send_node(8'h78, 7'd3);
        send_node(8'hFF, 7'd4);
        send_node(8'h00, 7'd0);
        send_node(CH_A + 8'd2, 7'd2);

        // A length of zero behaves as a length of one.
        drain_results();
        write_query(64'h0, '1, 64'd0);
        send_node(8'h00, 7'd0);
        send_node(8'h00, 7'd1);
        send_node(8'hFF, 7'd2);
        send_node(8'h00, 7'd3);

        // A length of 31, with noise in the unused upper data bits, saturates
        // to sixteen.
        drain_results();
        len_word = {$urandom, $urandom};
        len_word[LEN_W-1:0] = 5'd31;
        write_query('1, 64'h0123_4567_89AB_CDEF, len_word);
        send_node(8'hFF, 7'd1);
        send_node(8'hFF, 7'd2);
        send_node(8'h00, 7'd3);

        // Just past the limit also saturates.
        drain_results();
        write_query(random_query_word(1'b0), random_query_word(1'b0), 64'd17);
        send_node(CHAR_W'($urandom_range(255)), 7'd1);
        send_node(CHAR_W'($urandom_range(255)), 7'd2);

        // Random phases, each with a fresh query. Phase one dives to the
        // deepest node, phase four runs with no idling on either side, and
        // phase five pauses midway until all results are back.
        for (int p = 0; p < 8; p++) begin
            alpha = (p % 4) != 3;
            case (p)
                0:       len_word = 64'd1;
                2:       len_word = 64'd16;
                default: len_word = $urandom_range(16, 1);
            endcase
            drain_results();
            write_query(random_query_word(alpha), random_query_word(alpha), len_word);
            idle_en = (p != 4);
            run_walk((p == 1) ? 127 : 55, p == 1, alpha, (p == 5) ? 27 : -1);
        end
        idle_en = 1'b1;

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
